>>> rtl/core/btc_pkg.sv
// Shared types and constants for the balanced ternary converter.
// Holds the controller/datapath command and status structs and the power-of-three table.
// No dependencies.
`default_nettype none

package btc_pkg;

  // Fixed field widths of the stream payloads
  localparam int NUM_W       = 31;
  localparam int DEN_W       = 31;
  localparam int IN_TDATA_W  = 64;
  localparam int DIGIT_W     = 2;
  localparam int OUT_TDATA_W = 8;
  localparam int OUT_TUSER_W = 2;

  // Powers of three, 3^0 .. 3^40, all exact in 64 bits
  localparam int POW3_LAST = 40;
  typedef logic [POW3_LAST:0][63:0] pow3_tab_t;

  // Balanced digit codes
  localparam logic [DIGIT_W-1:0] DIG_ZERO = 2'b00;
  localparam logic [DIGIT_W-1:0] DIG_POS  = 2'b01;
  localparam logic [DIGIT_W-1:0] DIG_NEG  = 2'b11;

  function automatic pow3_tab_t pow3_table();
    pow3_tab_t   tab;
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i <= POW3_LAST; i++) begin
      tab[i] = p;
      p = p * 64'd3;
    end
    return tab;
  endfunction

  localparam pow3_tab_t POW3 = pow3_table();

  // Smallest t with 3^t >= 2^bits
  function automatic int pow3_exp_above(input int bits);
    logic [63:0] p;
    logic [63:0] lim;
    int          t;
    p   = 64'd1;
    lim = 64'd1 << bits;
    t   = 0;
    while (p < lim) begin
      p = p * 64'd3;
      t = t + 1;
    end
    return t;
  endfunction

  typedef struct packed {
    logic load_in;
    logic sweep_step;
    logic gen_init;
    logic gen_step;
    logic emit_init;
    logic rd_en;
    logic out_load;
    logic out_bad;
  } btc_cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic k_ok;
    logic gen_active;
    logic emit_last;
  } btc_sts_t;

endpackage

`default_nettype wire

>>> rtl/core/btc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module btc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/btc_dp.sv
// Datapath of the balanced ternary converter: power-of-three sweep, MSB-first
// digit generation into the digit store, emission counters and output payload.
// Depends on btc_pkg and btc_ram.
`default_nettype none

module btc_dp #(
  parameter int VALUE_BITS = 31,
  parameter int MAX_DIGITS = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [btc_pkg::NUM_W-1:0]         numerator,
  input  wire logic [btc_pkg::DEN_W-1:0]         denominator,
  input  wire btc_pkg::btc_cmd_t                 cmd,
  output btc_pkg::btc_sts_t                      sts,
  output logic      [btc_pkg::DIGIT_W-1:0]       out_digit,
  output logic                                   out_is_fraction,
  output logic                                   out_last,
  output logic                                   out_bad_denominator
);

  import btc_pkg::*;

  localparam int TOPMAX = pow3_exp_above(VALUE_BITS + 1);
  localparam int IW     = $clog2(TOPMAX + 1);
  localparam int EW     = $clog2(TOPMAX + MAX_DIGITS + 2);
  localparam int AW     = $clog2(MAX_DIGITS);
  localparam int PW     = VALUE_BITS + 3;
  localparam int RW     = VALUE_BITS + 2;
  localparam int TW     = $clog2(POW3_LAST + 1);

  // Operands, cut to the value width
  logic [NUM_W+VALUE_BITS-1:0] num_ext;
  logic [DEN_W+VALUE_BITS-1:0] den_ext;
  logic [VALUE_BITS-1:0]       a_in;
  logic [VALUE_BITS-1:0]       b_in;

  logic [VALUE_BITS-1:0] a_r, a_nxt;
  logic [VALUE_BITS-1:0] b_r, b_nxt;
  logic [IW-1:0]         idx_r, idx_nxt;
  logic [IW-1:0]         k_r, k_nxt;
  logic [IW-1:0]         top_r, top_nxt;
  logic                  kfound_r, kfound_nxt;
  logic                  topfound_r, topfound_nxt;
  logic [IW-1:0]         pos_r, pos_nxt;
  logic                  gact_r, gact_nxt;
  logic signed [RW-1:0]  res_r, res_nxt;
  logic [EW-1:0]         e_r, e_nxt;
  logic [EW-1:0]         nint_r, nint_nxt;
  logic [EW-1:0]         fend_r, fend_nxt;
  logic [EW-1:0]         total_r, total_nxt;
  logic [EW-1:0]         nintc_r, nintc_nxt;
  logic                  zint_r, zint_nxt;

  logic [DIGIT_W-1:0] digit_r, digit_nxt;
  logic               frac_r, frac_nxt;
  logic               last_r, last_nxt;
  logic               bad_r, bad_nxt;

  // Sweep compare
  logic [PW-1:0] pw_s;
  logic [PW-1:0] b_ext;
  logic [PW-1:0] a2_ext;
  logic          hit_k, hit_top, kf, tf;

  // Generation step
  logic [VALUE_BITS:0]  pw_g;
  logic signed [RW-1:0] pw_gs;
  logic signed [RW-1:0] half_s;
  logic                 gt, lt;
  logic [DIGIT_W-1:0]   gdig;
  logic                 int_gt;
  logic [IW-1:0]        npos;

  logic               ram_we;
  logic [DIGIT_W-1:0] ram_rdata;
  logic [EW-1:0]      max_e;

  assign num_ext = {{VALUE_BITS{1'b0}}, numerator};
  assign den_ext = {{VALUE_BITS{1'b0}}, denominator};
  assign a_in    = num_ext[VALUE_BITS-1:0];
  assign b_in    = den_ext[VALUE_BITS-1:0];
  assign max_e   = EW'(MAX_DIGITS);

  assign pw_s    = POW3[TW'(idx_r)][PW-1:0];
  assign b_ext   = {3'b000, b_r};
  assign a2_ext  = {2'b00, a_r, 1'b0};
  assign hit_k   = !kfound_r && (b_ext == pw_s);
  assign hit_top = !topfound_r && (a2_ext < pw_s);
  assign kf      = kfound_r || hit_k;
  assign tf      = topfound_r || hit_top;

  assign pw_g   = POW3[TW'(pos_r)][VALUE_BITS:0];
  assign pw_gs  = $signed({1'b0, pw_g});
  assign half_s = $signed({2'b00, pw_g[VALUE_BITS:1]});
  assign gt     = res_r > half_s;
  assign lt     = res_r < -half_s;
  assign gdig   = gt ? DIG_POS : (lt ? DIG_NEG : DIG_ZERO);

  assign int_gt = top_r > k_r;
  assign npos   = int_gt ? top_r : k_r;

  assign ram_we = cmd.gen_step && (e_r < max_e);

  always_comb begin
    a_nxt        = a_r;
    b_nxt        = b_r;
    idx_nxt      = idx_r;
    k_nxt        = k_r;
    top_nxt      = top_r;
    kfound_nxt   = kfound_r;
    topfound_nxt = topfound_r;
    pos_nxt      = pos_r;
    gact_nxt     = gact_r;
    res_nxt      = res_r;
    e_nxt        = e_r;
    nint_nxt     = nint_r;
    fend_nxt     = fend_r;
    total_nxt    = total_r;
    nintc_nxt    = nintc_r;
    zint_nxt     = zint_r;
    digit_nxt    = digit_r;
    frac_nxt     = frac_r;
    last_nxt     = last_r;
    bad_nxt      = bad_r;

    if (cmd.load_in) begin
      a_nxt        = a_in;
      b_nxt        = b_in;
      idx_nxt      = '0;
      kfound_nxt   = 1'b0;
      topfound_nxt = 1'b0;
    end

    if (cmd.sweep_step) begin
      if (hit_k) begin
        k_nxt = idx_r;
      end
      if (hit_top) begin
        top_nxt = idx_r;
      end
      kfound_nxt   = kf;
      topfound_nxt = tf;
      idx_nxt      = idx_r + IW'(1);
    end

    if (cmd.gen_init) begin
      gact_nxt = (npos != '0);
      pos_nxt  = npos - IW'(1);
      res_nxt  = $signed({2'b00, a_r});
      e_nxt    = int_gt ? '0 : EW'(1);
      nint_nxt = int_gt ? EW'(top_r - k_r) : EW'(1);
      fend_nxt = int_gt ? EW'(top_r - k_r) : EW'(1);
      zint_nxt = !int_gt;
    end

    // Greedy balanced digit at the current position, most significant first
    if (cmd.gen_step) begin
      if (gt) begin
        res_nxt = res_r - pw_gs;
      end else if (lt) begin
        res_nxt = res_r + pw_gs;
      end
      if ((pos_r < k_r) && (gdig != DIG_ZERO)) begin
        fend_nxt = e_r + EW'(1);
      end
      e_nxt = e_r + EW'(1);
      if (pos_r == '0) begin
        gact_nxt = 1'b0;
      end else begin
        pos_nxt = pos_r - IW'(1);
      end
    end

    // Clip the run to the store depth
    if (cmd.emit_init) begin
      e_nxt     = '0;
      total_nxt = (fend_r > max_e) ? max_e : fend_r;
      nintc_nxt = (nint_r > max_e) ? max_e : nint_r;
    end

    if (cmd.out_load) begin
      if (cmd.out_bad) begin
        digit_nxt = DIG_ZERO;
        frac_nxt  = 1'b0;
        last_nxt  = 1'b1;
        bad_nxt   = 1'b1;
      end else begin
        digit_nxt = (zint_r && (e_r == '0)) ? DIG_ZERO : ram_rdata;
        frac_nxt  = (e_r >= nintc_r);
        last_nxt  = sts.emit_last;
        bad_nxt   = 1'b0;
        e_nxt     = e_r + EW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kfound_r   <= 1'b0;
      topfound_r <= 1'b0;
      gact_r     <= 1'b0;
    end else begin
      kfound_r   <= kfound_nxt;
      topfound_r <= topfound_nxt;
      gact_r     <= gact_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    idx_r   <= idx_nxt;
    k_r     <= k_nxt;
    top_r   <= top_nxt;
    pos_r   <= pos_nxt;
    res_r   <= res_nxt;
    e_r     <= e_nxt;
    nint_r  <= nint_nxt;
    fend_r  <= fend_nxt;
    total_r <= total_nxt;
    nintc_r <= nintc_nxt;
    zint_r  <= zint_nxt;
    digit_r <= digit_nxt;
    frac_r  <= frac_nxt;
    last_r  <= last_nxt;
    bad_r   <= bad_nxt;
  end

  btc_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_digit_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (e_r[AW-1:0]),
    .wdata (gdig),
    .re    (cmd.rd_en),
    .raddr (e_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    sts.sweep_done = (idx_r == IW'(TOPMAX)) || (kf && tf) || (!kf && (b_ext < pw_s));
    sts.k_ok       = kfound_r;
    sts.gen_active = gact_r;
    sts.emit_last  = (e_r == total_r - EW'(1));
  end

  assign out_digit           = digit_r;
  assign out_is_fraction     = frac_r;
  assign out_last            = last_r;
  assign out_bad_denominator = bad_r;

  a_step_only_active: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.gen_step |-> gact_r)
    else $error("digit generation stepped past position zero");

  a_emit_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && !cmd.out_bad) |-> (e_r < total_r))
    else $error("emission index ran past the digit count");

  a_run_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_init |=> (total_r != '0))
    else $error("conversion produced an empty digit run");

endmodule

`default_nettype wire

>>> rtl/core/btc_ctrl.sv
// Controller of the balanced ternary converter: sequences sweep, digit
// generation and emission, and owns the output valid flag.
// Depends on btc_pkg.
`default_nettype none

module btc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output btc_pkg::btc_cmd_t      cmd,
  input  wire btc_pkg::btc_sts_t sts
);

  import btc_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SWEEP = 4'd1;
  localparam logic [3:0] ST_CHK   = 4'd2;
  localparam logic [3:0] ST_BAD   = 4'd3;
  localparam logic [3:0] ST_GINIT = 4'd4;
  localparam logic [3:0] ST_GEN   = 4'd5;
  localparam logic [3:0] ST_EINIT = 4'd6;
  localparam logic [3:0] ST_ERD   = 4'd7;
  localparam logic [3:0] ST_ELD   = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       out_vld_r, out_vld_nxt;
  logic       out_free;

  assign out_free = !out_vld_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_done) begin
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        state_nxt = sts.k_ok ? ST_GINIT : ST_BAD;
      end
      ST_BAD: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_bad  = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_GINIT: begin
        cmd.gen_init = 1'b1;
        state_nxt    = ST_GEN;
      end
      ST_GEN: begin
        if (sts.gen_active) begin
          cmd.gen_step = 1'b1;
        end else begin
          state_nxt = ST_EINIT;
        end
      end
      ST_EINIT: begin
        cmd.emit_init = 1'b1;
        state_nxt     = ST_ERD;
      end
      ST_ERD: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_ELD;
      end
      ST_ELD: begin
        // Hold until the output register frees up
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = sts.emit_last ? ST_IDLE : ST_ERD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_vld_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_vld_r || out_tready))
    else $error("output register loaded while holding an untaken transaction");

  a_bad_path: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHK && !sts.k_ok) |=> (state_r == ST_BAD))
    else $error("bad denominator not reported");

  a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ELD && cmd.out_load && sts.emit_last) |=> in_tready)
    else $error("input not reopened after final digit");

endmodule

`default_nettype wire

>>> rtl/core/balanced_ternary_converter_unit.sv
// Converts numerator / 3^k to balanced ternary, one digit per output transaction,
// most significant first: integer digits (a lone 0 when the integer part is zero),
// then fraction digits with trailing zeros dropped; tlast marks the final digit. A
// denominator that is not a power of three yields a single transaction with the
// bad-denominator flag set. One item is handled at a time. An accepted item goes
// through a sweep over a power-of-three table that finds k and the digit count,
// MSB-first digit generation into the digit store, and emission, where each digit
// passes the registered read of the digit store and then the output register; once
// the final digit is loaded the unit returns to idle and can take the next item. A
// bad denominator goes from the sweep through a check state to the output register.
// A digit that waits on out_tready holds up the whole item. The digit store needs
// no clearing after reset. Depends on btc_pkg, btc_ctrl, btc_dp.
`default_nettype none

module balanced_ternary_converter_unit #(
  parameter int VALUE_BITS = 31,
  parameter int MAX_DIGITS = 64
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // [30:0] numerator, [61:31] denominator, [63:62] zero
  input  wire logic [btc_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [1:0] digit (signed), [7:2] zero
  output logic      [btc_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [0] is_fraction, [1] bad_denominator
  output logic      [btc_pkg::OUT_TUSER_W-1:0]    out_tuser,
  output logic                                    out_tlast
);

  import btc_pkg::*;

  btc_cmd_t           cmd;
  btc_sts_t           sts;
  logic [DIGIT_W-1:0] digit;
  logic               is_fraction;
  logic               bad_den;

  btc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  btc_dp #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .numerator           (in_tdata[NUM_W-1:0]),
    .denominator         (in_tdata[NUM_W+DEN_W-1:NUM_W]),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_digit           (digit),
    .out_is_fraction     (is_fraction),
    .out_last            (out_tlast),
    .out_bad_denominator (bad_den)
  );

  assign out_tdata = {{(OUT_TDATA_W-DIGIT_W){1'b0}}, digit};
  assign out_tuser = {bad_den, is_fraction};

endmodule

`default_nettype wire
